// ===== sv/binary_hit_miss_thinning_pass_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef BINARY_HIT_MISS_THINNING_PASS_MACROS_SVH
`define BINARY_HIT_MISS_THINNING_PASS_MACROS_SVH
`ifndef SYNTHESIS
`define BHM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define BHM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BHM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BHM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/bhm_pkg.sv =====
package bhm_pkg;

   localparam int MaxWidthDefault = 1024;
   localparam int HeightLimit     = 4096;

   localparam logic [1:0] MODE_SHRINK = 2'd0;
   localparam logic [1:0] MODE_THIN   = 2'd1;
   localparam logic [1:0] MODE_SKEL   = 2'd2;

   localparam logic [1:0] REG_MODE   = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   localparam logic [1:0]  ModeReset   = MODE_THIN;
   localparam logic [10:0] WidthReset  = 11'd640;
   localparam logic [12:0] HeightReset = 13'd480;

   localparam logic [7:0] ShrinkCond [58] = '{
      8'h40,8'h10,8'h04,8'h01,8'h80,8'h20,8'h08,8'h02,
      8'hC0,8'h60,8'h30,8'h18,8'h0C,8'h06,8'h03,8'h81,
      8'hC1,8'h70,8'h1C,8'h07,8'hB0,8'hA1,8'h68,8'hC2,
      8'hE0,8'h38,8'h0E,8'h83,8'hB1,8'h6C,
      8'hF0,8'hE1,8'h78,8'h3C,8'h1E,8'h0F,8'h87,8'hC3,
      8'hF1,8'h7C,8'h1F,8'hC7,8'hE3,8'hF8,8'h3E,8'h8F,
      8'hF3,8'hE7,8'hFC,8'hF9,8'h7E,8'h3F,8'h9F,8'hCF,
      8'hF7,8'hFD,8'h7F,8'hDF};
   localparam logic [7:0] ThinCond [46] = '{
      8'hA0,8'h28,8'h0A,8'h82,8'h70,8'h1C,8'h07,8'hC1,
      8'hB0,8'hA1,8'h68,8'hC2,8'hE0,8'h38,8'h0E,8'h83,
      8'hF0,8'hE1,8'h78,8'h3C,8'h1E,8'h0F,8'h87,8'hC3,
      8'hB1,8'h6C,
      8'hF1,8'h7C,8'h1F,8'hC7,8'hE3,8'hF8,8'h3E,8'h8F,
      8'hF3,8'hE7,8'hFC,8'hF9,8'h7E,8'h3F,8'h9F,8'hCF,
      8'hF7,8'hFD,8'h7F,8'hDF};
   localparam logic [7:0] SkelCond [40] = '{
      8'hA0,8'h28,8'h0A,8'h82,8'hC1,8'h70,8'h1C,8'h07,
      8'hF0,8'hE1,8'h78,8'h3C,8'h1E,8'h0F,8'h87,8'hC3,
      8'hF1,8'h7C,8'h1F,8'hC7,8'hE3,8'hF8,8'h3E,8'h8F,
      8'hF3,8'hE7,8'hFC,8'hF9,8'h7E,8'h3F,8'h9F,8'hCF,
      8'hF7,8'hFD,8'h7F,8'hDF,8'hFB,8'hFE,8'hBF,8'hEF};
   localparam logic [7:0] StExact [28] = '{
      8'h40,8'h10,8'h02,8'h80,
      8'hC0,8'h60,8'h30,8'h18,8'h0C,8'h06,8'h03,8'h81,
      8'h68,8'hB0,8'hA1,8'hC2,
      8'h64,8'h19,8'h4C,8'h13,8'hC4,8'h31,8'h46,8'h91,8'hE4,8'h39,8'h4E,8'h93};
   localparam logic [7:0] KExact [12] = '{
      8'h01,8'h04,8'h40,8'h10,8'h02,8'h80,8'h08,8'h20,8'hA0,8'h28,8'h82,8'h0A};
   // Masked entries are {pattern, care mask}.
   localparam logic [15:0] StHead [9] = '{
      16'h3838,16'hA8EB,16'hA8BE,16'h8ABE,16'h8AEB,
      16'h2AAF,16'h2AFA,16'hA2FA,16'hA2AF};
   localparam logic [15:0] KHead [6] = '{
      16'h3838,16'h8383,16'hA8A8,16'h2A2A,16'h8A8A,16'hA2A2};
   localparam logic [15:0] SharedMasked [32] = '{
      16'h5157,16'h15D5,16'h1575,16'h455D,16'h5257,16'h54D5,16'h2575,16'h495D,
      16'h5357,16'h55D5,16'h3575,16'h4D5D,16'h5457,16'h94D5,16'h4575,16'h515D,
      16'h5557,16'h95D5,16'h5575,16'h555D,16'h5657,16'hD4D5,16'h6575,16'h595D,
      16'h5757,16'hD5D5,16'h7575,16'h5D5D,16'hA4EE,16'h29BB,16'h4AEE,16'h92BB};

   // Window taps: index r*3+c, r=0 oldest row, c=0 oldest column.
   typedef logic [8:0] win_type;

   // Control carried along with one pixel position.
   typedef struct packed {
      logic valid;
      logic top;
      logic bottom;
      logic left;
      logic right;
   } pos_type;

   function automatic logic [7:0] pattern_of(input win_type w, input pos_type p);
      logic [7:0] pat;
      // Center is w[4]; newest column is c=2 (east), newest row r=2 (south).
      pat[7] = w[5] & ~p.right;
      pat[6] = w[2] & ~p.right & ~p.top;
      pat[5] = w[1] & ~p.top;
      pat[4] = w[0] & ~p.left & ~p.top;
      pat[3] = w[3] & ~p.left;
      pat[2] = w[6] & ~p.left & ~p.bottom;
      pat[1] = w[7] & ~p.bottom;
      pat[0] = w[8] & ~p.right & ~p.bottom;
      return pat;
   endfunction

   function automatic logic cond_hit(input logic [1:0] mode, input logic [7:0] pat);
      logic hit;
      hit = 1'b0;
      case (mode)
         MODE_SHRINK: for (int i = 0; i < 58; i++) hit |= (ShrinkCond[i] == pat);
         MODE_THIN:   for (int i = 0; i < 46; i++) hit |= (ThinCond[i] == pat);
         MODE_SKEL:   for (int i = 0; i < 40; i++) hit |= (SkelCond[i] == pat);
         default:     hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic logic uncond_hit(input logic [1:0] mode, input logic [7:0] pat);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < 32; i++)
         hit |= ((pat & SharedMasked[i][7:0]) == SharedMasked[i][15:8]);
      if (mode == MODE_SKEL) begin
         for (int i = 0; i < 12; i++) hit |= (KExact[i] == pat);
         for (int i = 0; i < 6; i++) hit |= ((pat & KHead[i][7:0]) == KHead[i][15:8]);
      end else begin
         for (int i = 0; i < 28; i++) hit |= (StExact[i] == pat);
         for (int i = 0; i < 9; i++) hit |= ((pat & StHead[i][7:0]) == StHead[i][15:8]);
      end
      return hit;
   endfunction

endpackage

// ===== sv/bhm_ram.sv =====
module bhm_ram #(
   parameter int Width = 1,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== sv/bhm_window.sv =====
// 3x3 window fed by a two-row line buffer. The RAM holds, per column, the
// pixel of the row above (bit 0) and two rows above (bit 1). The window output
// already includes the column being pushed in the current cycle.
module bhm_window #(
   parameter int MaxWidth = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          shift,
   input  logic [$clog2(MaxWidth)-1:0]   col,
   input  logic [$clog2(MaxWidth)-1:0]   next_col,
   input  logic                          pix,
   input  logic                          clear,
   output bhm_pkg::win_type              win
);
   import bhm_pkg::*;
   localparam int AddrW = $clog2(MaxWidth);

   logic [1:0] rd_data;
   logic [1:0] col_in;
   win_type    win_ff;
   win_type    win_in;
   win_type    win_now;
   logic [AddrW-1:0] rd_addr;

   // Prefetch the column of the next shift; hold it while stalled.
   assign rd_addr = shift ? next_col : col;

   bhm_ram #(.Width(2), .Depth(MaxWidth)) u_ram (
      .clock  (clock),
      .wr_en  (shift),
      .wr_addr(col),
      .wr_data({col_in[0], pix}),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Entries of never-written columns only feed taps that the edge masks drop.
   assign col_in = rd_data;

   always_comb begin
      win_now[0] = win_ff[1]; win_now[1] = win_ff[2]; win_now[2] = col_in[1];
      win_now[3] = win_ff[4]; win_now[4] = win_ff[5]; win_now[5] = col_in[0];
      win_now[6] = win_ff[7]; win_now[7] = win_ff[8]; win_now[8] = pix;
   end

   assign win_in = shift ? win_now : win_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         win_ff <= '0;
      end else begin
         win_ff <= win_in;
      end
   end
   assign win = win_now;
endmodule

// ===== sv/binary_hit_miss_thinning_pass.sv =====
// One pass of two-stage hit-or-miss thinning (shrink, thin or skeletonize)
// on a raster stream of binary pixels, one request per clock. Each request
// carries a pixel or a flush marker; the result for pixel q appears with the
// request at stream position q + 2*W + 2, so every frame must be followed by
// 2*W + 2 flush requests to drain it. The first 2*W + 2 requests of a frame
// produce no result. The last pixel of a frame carries last. Writing width
// or height restarts the frame; mode takes effect with the next request.
// Out-of-frame neighbors count as zero. Two line buffers, one for source
// pixels and one for stage-one marks, each a 2-bit by MaxWidth RAM, hold the
// rows above. Throughput is one request per cycle unless the response is stalled;
// an accepted request's result is registered, behind the 2*W + 2 stream delay.
`include "binary_hit_miss_thinning_pass_macros.svh"
module binary_hit_miss_thinning_pass #(
   parameter int MaxWidth = bhm_pkg::MaxWidthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // bit 0 pixel_in
   input  logic        req_tuser,   // flush
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // bit 0 pixel_out
   output logic        rsp_tlast,   // last_pixel
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);
   import bhm_pkg::*;
   localparam int AddrW = $clog2(MaxWidth);
   localparam int CW = $clog2(MaxWidth + 1);

   logic [1:0]  mode_ff;
   logic [10:0] width_ff;
   logic [12:0] height_ff;
   logic [CW-1:0] w;
   logic [12:0] h;
   logic [CW-1:0] col_ff, col_in;
   logic [13:0] row_ff, row_in;   // Rows run up to H + 2 while draining.
   logic started_ff, started_in;
   logic rsp_valid_ff;
   logic rsp_pix_ff, rsp_last_ff;
   logic accept, step, restart;
   logic fl, pix_src;
   logic [AddrW-1:0] col_a, ncol_a, col_m, ncol_m;
   logic [CW-1:0] next_col;
   win_type src_win, mark_win;
   pos_type mpos, opos;
   logic mark_bit, out_valid, out_last, out_pix;
   logic [CW-1:0] mcol, ocol;
   logic [13:0] mrow, orow;

   always_comb begin
      w = (width_ff < 11'd3) ? CW'(3) :
          (int'(width_ff) > MaxWidth) ? CW'(MaxWidth) : CW'(width_ff);
      h = (height_ff < 13'd3) ? 13'd3 :
          (height_ff > 13'(HeightLimit)) ? 13'(HeightLimit) : height_ff;
   end

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept  = req_tvalid & req_tready;
   assign fl      = req_tuser;
   // A flush at frame position zero is dropped without any effect.
   assign step    = accept & ~(~started_ff & fl);
   assign restart = csr_we & ((csr_index == REG_WIDTH) | (csr_index == REG_HEIGHT));
   assign pix_src = (row_ff < 14'(h)) & ~fl & req_tdata[0];

   // Stage-one center trails the write position by W+1, output by 2W+2.
   // Positions are tracked as (row, col) pairs.
   always_comb begin
      mcol = (col_ff == '0) ? CW'(w - 1'b1) : CW'(col_ff - 1'b1);
      mrow = (col_ff == '0) ? 14'(row_ff - 14'd2) : 14'(row_ff - 14'd1);
      ocol = (mcol == '0) ? CW'(w - 1'b1) : CW'(mcol - 1'b1);
      orow = (mcol == '0) ? 14'(mrow - 14'd2) : 14'(mrow - 14'd1);
   end

   // The output center may sit in the last rows while the stage-one center
   // has already moved past the frame during the drain.
   always_comb begin
      mpos.valid  = ~mrow[13] & (mrow < 14'(h)) &
                    ~((col_ff == '0) & (row_ff < 14'd2));
      mpos.top    = (mrow == '0);
      mpos.bottom = (mrow == 14'(h - 1'b1));
      mpos.left   = (mcol == '0);
      mpos.right  = (mcol == CW'(w - 1'b1));
      opos.valid  = ~orow[13] & (orow < 14'(h)) & (row_ff >= 14'd2) &
                    ~((row_ff == 14'd2) & (col_ff < CW'(2)));
      opos.top    = (orow == '0);
      opos.bottom = (orow == 14'(h - 1'b1));
      opos.left   = (ocol == '0);
      opos.right  = (ocol == CW'(w - 1'b1));
   end

   assign next_col = (col_ff == CW'(w - 1'b1)) ? '0 : CW'(col_ff + 1'b1);
   assign col_a  = AddrW'(col_ff);
   assign ncol_a = AddrW'(next_col);
   assign col_m  = AddrW'(mcol);
   assign ncol_m = AddrW'(col_ff);

   // Source window: column col_ff is pushed; its center is (mrow, mcol).
   bhm_window #(.MaxWidth(MaxWidth)) u_src (
      .clock(clock), .reset(reset), .shift(step), .col(col_a), .next_col(ncol_a),
      .pix(pix_src), .clear(restart), .win(src_win)
   );

   assign mark_bit = mpos.valid & src_win[4] & cond_hit(mode_ff, pattern_of(src_win, mpos));

   // Mark window: column mcol is pushed; its center is the output position.
   bhm_window #(.MaxWidth(MaxWidth)) u_mark (
      .clock(clock), .reset(reset), .shift(step), .col(col_m), .next_col(ncol_m),
      .pix(mark_bit), .clear(restart), .win(mark_win)
   );

   // The oldest tap of the source window is the source pixel of the output
   // center, which an unmarked pixel passes through unchanged.
   assign out_valid = opos.valid;
   assign out_last  = opos.valid & (orow == 14'(h - 1'b1)) & (ocol == CW'(w - 1'b1));
   assign out_pix   = mark_win[4] ? uncond_hit(mode_ff, pattern_of(mark_win, opos))
                                  : src_win[0];

   always_comb begin
      started_in = started_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (step) begin
         started_in = ~out_last;
         if (out_last) begin
            col_in = '0;
            row_in = '0;
         end else begin
            col_in = next_col;
            row_in = (col_ff == CW'(w - 1'b1)) ? 14'(row_ff + 1'b1) : row_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ModeReset;
         width_ff <= WidthReset;
         height_ff <= HeightReset;
         col_ff <= '0;
         row_ff <= '0;
         started_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            rsp_valid_ff <= step & out_valid;
         end
         if (restart) begin
            col_ff <= '0;
            row_ff <= '0;
            started_ff <= 1'b0;
         end else begin
            col_ff <= col_in;
            row_ff <= row_in;
            started_ff <= started_in;
         end
         if (csr_we) begin
            case (csr_index)
               REG_MODE:   mode_ff <= csr_wdata[1:0];
               REG_WIDTH:  width_ff <= csr_wdata[10:0];
               REG_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step & req_tready) begin
         rsp_pix_ff <= out_pix;
         rsp_last_ff <= out_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_pix_ff};
   assign rsp_tlast  = rsp_last_ff;

   `BHM_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid & ~rsp_tready, rsp_tvalid)
   `BHM_ASSERT_IMPL(a_col_range, clock, reset, 1'b1, col_ff < w)
   `BHM_ASSERT_NEXT(a_last_wraps, clock, reset, step & out_last & ~restart,
                    (col_ff == '0) && (row_ff == '0))
endmodule
